// ----- design/spt_pkg.sv -----
// Shared types, constants and helpers for the square pyramid tessellator.
// No dependencies; every design file imports this package.
`default_nettype none

package spt_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int COORD_W        = 32;
  localparam int DIM_W          = 31;
  localparam int MAG_W          = 64;
  localparam int NORM_W         = 31;
  localparam int MSB_W          = 6;
  localparam int ROOT_W         = 32;
  localparam int ROOT_STEPS     = 32;
  localparam int ROOT_PER_STAGE = 2;
  localparam int ROOT_STAGES    = ROOT_STEPS / ROOT_PER_STAGE;
  localparam int PT_W           = 34;
  localparam int NUM_PTS        = 5;
  localparam int NUM_OFFS       = 9;
  localparam int FACE_W         = 3;
  localparam int GAP_W          = 3;
  localparam logic [GAP_W-1:0] ITEM_GAP = 3'd5;

  // Point slots: apex, then the four base corners.
  localparam logic [2:0] PT_APEX = 3'd0;
  localparam logic [2:0] PT_MM   = 3'd1;
  localparam logic [2:0] PT_MP   = 3'd2;
  localparam logic [2:0] PT_PM   = 3'd3;
  localparam logic [2:0] PT_PP   = 3'd4;

  typedef enum logic [FACE_W-1:0] {
    FACE0 = 3'd0,
    FACE1 = 3'd1,
    FACE2 = 3'd2,
    FACE3 = 3'd3,
    FACE4 = 3'd4,
    FACE5 = 3'd5
  } face_t;

  localparam face_t FACE_LAST = FACE5;

  typedef logic signed [PT_W-1:0]    pt_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] center;
    logic [DIM_W-1:0]        height;
    logic [DIM_W-1:0]        size;
  } side_t;

  function automatic coord_t sat32(input pt_t v);
    coord_t r;
    if (v > pt_t'(32'sh7FFFFFFF)) begin
      r = 32'sh7FFFFFFF;
    end else if (v < pt_t'(-33'sh080000000)) begin
      r = 32'sh80000000;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/spt_norm.sv -----
// Pipelined vector normalizer: range shift, sum of squares, integer square
// root (two bits a stage) and restoring division (one bit a stage). Uses spt_pkg.
`default_nettype none

module spt_norm import spt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  logic [2:0][MAG_W-1:0]      in_mag,
  input  logic [2:0]                 in_neg,
  output logic                       out_vld,
  output logic [2:0][FRAC_BITS+1:0]  out_unit,
  output logic                       out_zero
);

  localparam int QW = FRAC_BITS + 1;
  localparam int NW = NORM_W + FRAC_BITS + 1;
  localparam int UW = FRAC_BITS + 2;
  localparam int SQ_W = 2 * NORM_W;

  typedef struct packed {
    logic [MAG_W-1:0]       x;
    logic [MAG_W-1:0]       res;
    logic [2:0][NORM_W-1:0] m;
    logic [2:0]             neg;
    logic                   zero;
  } root_t;

  typedef struct packed {
    logic [2:0][NW-1:0]     n;
    logic [2:0][ROOT_W-1:0] r;
    logic [2:0][QW-1:0]     q;
    logic [ROOT_W-1:0]      len;
    logic [2:0]             neg;
    logic                   zero;
  } div_t;

  // stage a: largest magnitude
  logic                  a_vld_r;
  logic [2:0][MAG_W-1:0] a_m_r;
  logic [MAG_W-1:0]      a_mx_r;
  logic [2:0]            a_neg_r;
  logic [MAG_W-1:0]      mx_nxt;

  always_comb begin
    mx_nxt = in_mag[0];
    if (in_mag[1] > mx_nxt) mx_nxt = in_mag[1];
    if (in_mag[2] > mx_nxt) mx_nxt = in_mag[2];
  end

  // stage b: leading one of the largest magnitude
  logic                  b_vld_r;
  logic [2:0][MAG_W-1:0] b_m_r;
  logic [MSB_W-1:0]      b_msb_r;
  logic [2:0]            b_neg_r;
  logic                  b_zero_r;
  logic [MSB_W-1:0]      msb_nxt;

  always_comb begin
    msb_nxt = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (a_mx_r[i]) msb_nxt = MSB_W'(i);
    end
  end

  // stage c: common shift so the largest lies in [2^30, 2^31)
  logic                   c_vld_r;
  logic [2:0][NORM_W-1:0] c_m_r;
  logic [2:0]             c_neg_r;
  logic                   c_zero_r;
  logic [2:0][NORM_W-1:0] sh_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (b_msb_r > MSB_W'(NORM_W - 1)) begin
        sh_nxt[i] = NORM_W'(b_m_r[i] >> (b_msb_r - MSB_W'(NORM_W - 1)));
      end else begin
        sh_nxt[i] = NORM_W'(b_m_r[i] << (MSB_W'(NORM_W - 1) - b_msb_r));
      end
    end
  end

  // stage d: squares
  logic                   d_vld_r;
  logic [2:0][SQ_W-1:0]   d_sq_r;
  logic [2:0][NORM_W-1:0] d_m_r;
  logic [2:0]             d_neg_r;
  logic                   d_zero_r;

  root_t root_r   [ROOT_STAGES+1];
  logic  root_vld_r [ROOT_STAGES+1];
  root_t root_nxt [ROOT_STAGES];

  div_t  div_r    [QW+1];
  logic  div_vld_r [QW+1];
  div_t  div_nxt  [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      root_vld_r[0] <= 1'b0;
      div_vld_r[0]  <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
      root_vld_r[0] <= d_vld_r;
      div_vld_r[0]  <= root_vld_r[ROOT_STAGES];
      out_vld <= div_vld_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    a_m_r   <= in_mag;
    a_mx_r  <= mx_nxt;
    a_neg_r <= in_neg;

    b_m_r    <= a_m_r;
    b_msb_r  <= msb_nxt;
    b_neg_r  <= a_neg_r;
    b_zero_r <= (a_mx_r == '0);

    c_m_r    <= sh_nxt;
    c_neg_r  <= b_neg_r;
    c_zero_r <= b_zero_r;

    for (int i = 0; i < 3; i++) begin
      d_sq_r[i] <= c_m_r[i] * c_m_r[i];
    end
    d_m_r    <= c_m_r;
    d_neg_r  <= c_neg_r;
    d_zero_r <= c_zero_r;

    root_r[0].x    <= MAG_W'(d_sq_r[0]) + MAG_W'(d_sq_r[1]) + MAG_W'(d_sq_r[2]);
    root_r[0].res  <= '0;
    root_r[0].m    <= d_m_r;
    root_r[0].neg  <= d_neg_r;
    root_r[0].zero <= d_zero_r;

    div_r[0] <= div_nxt[QW];
  end

  genvar k;
  generate
    for (k = 0; k < ROOT_STAGES; k++) begin : g_root
      always_comb begin : step
        logic [MAG_W-1:0] x_w;
        logic [MAG_W-1:0] res_w;
        logic [MAG_W-1:0] bit_w;
        root_nxt[k] = root_r[k];
        x_w   = root_r[k].x;
        res_w = root_r[k].res;
        for (int t = 0; t < ROOT_PER_STAGE; t++) begin
          bit_w = MAG_W'(1) << (MAG_W - 2 - 2 * (ROOT_PER_STAGE * k + t));
          if (x_w >= res_w + bit_w) begin
            x_w   = x_w - (res_w + bit_w);
            res_w = (res_w >> 1) + bit_w;
          end else begin
            res_w = res_w >> 1;
          end
        end
        root_nxt[k].x   = x_w;
        root_nxt[k].res = res_w;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          root_vld_r[k+1] <= 1'b0;
        end else begin
          root_vld_r[k+1] <= root_vld_r[k];
        end
      end

      always_ff @(posedge clk) begin
        root_r[k+1] <= root_nxt[k];
      end
    end
  endgenerate

  // numerator m * 2^F + len/2 and the initial partial remainder
  always_comb begin : num
    logic [ROOT_W-1:0] len_w;
    len_w = root_r[ROOT_STAGES].res[ROOT_W-1:0];
    div_nxt[QW].len  = len_w;
    div_nxt[QW].neg  = root_r[ROOT_STAGES].neg;
    div_nxt[QW].zero = root_r[ROOT_STAGES].zero;
    div_nxt[QW].q    = '0;
    for (int i = 0; i < 3; i++) begin
      div_nxt[QW].n[i] = {root_r[ROOT_STAGES].m[i], FRAC_BITS'(0)} + NW'(len_w >> 1);
      div_nxt[QW].r[i] = ROOT_W'(div_nxt[QW].n[i] >> QW);
    end
  end

  genvar j;
  generate
    for (j = 0; j < QW; j++) begin : g_div
      always_comb begin : step
        logic [ROOT_W:0] r2;
        div_nxt[j] = div_r[j];
        for (int i = 0; i < 3; i++) begin
          r2 = {div_r[j].r[i], div_r[j].n[i][FRAC_BITS-j]};
          div_nxt[j].q[i] = {div_r[j].q[i][QW-2:0], 1'b0};
          if (r2 >= {1'b0, div_r[j].len}) begin
            r2 = r2 - {1'b0, div_r[j].len};
            div_nxt[j].q[i][0] = 1'b1;
          end
          div_nxt[j].r[i] = r2[ROOT_W-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          div_vld_r[j+1] <= 1'b0;
        end else begin
          div_vld_r[j+1] <= div_vld_r[j];
        end
      end

      always_ff @(posedge clk) begin
        div_r[j+1] <= div_nxt[j];
      end
    end
  endgenerate

  // apply sign, force zero for a null vector
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (div_r[QW].zero) begin
        out_unit[i] <= '0;
      end else if (div_r[QW].neg[i]) begin
        out_unit[i] <= UW'(0) - {1'b0, div_r[QW].q[i]};
      end else begin
        out_unit[i] <= {1'b0, div_r[QW].q[i]};
      end
    end
    out_zero <= div_r[QW].zero;
  end

endmodule

`default_nettype wire

// ----- design/spt_emit.sv -----
// Offset scaling, point assembly, saturation and the six-face sequencer.
// Depends on spt_pkg.
`default_nettype none

module spt_emit import spt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  logic [2:0][FRAC_BITS+1:0] in_ua,
  input  logic [2:0][FRAC_BITS+1:0] in_us,
  input  logic [2:0][FRAC_BITS+1:0] in_ux,
  input  side_t                     in_side,
  input  logic                      in_deg,
  output logic                      out_valid,
  output coord_t                    out_vertex_a_x,
  output coord_t                    out_vertex_a_y,
  output coord_t                    out_vertex_a_z,
  output coord_t                    out_vertex_b_x,
  output coord_t                    out_vertex_b_y,
  output coord_t                    out_vertex_b_z,
  output coord_t                    out_vertex_c_x,
  output coord_t                    out_vertex_c_y,
  output coord_t                    out_vertex_c_z,
  output logic [FACE_W-1:0]         out_face_number,
  output logic                      out_final_face,
  output logic                      out_degenerate
);

  localparam int UW = FRAC_BITS + 2;
  localparam int PW = FRAC_BITS + 1 + DIM_W;

  // e1: |unit| * length
  logic                    e1_vld_r;
  logic [PW-1:0]           e1_prod_r [NUM_OFFS];
  logic [NUM_OFFS-1:0]     e1_neg_r;
  logic [2:0][COORD_W-1:0] e1_c_r;
  logic                    e1_deg_r;
  logic [UW-1:0]           u_w   [NUM_OFFS];
  logic [DIM_W-1:0]        len_w [NUM_OFFS];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_w[i]       = in_ua[i];
      u_w[3 + i]   = in_us[i];
      u_w[6 + i]   = in_ux[i];
      len_w[i]     = in_side.height;
      len_w[3 + i] = in_side.size;
      len_w[6 + i] = in_side.size;
    end
  end

  // e2: round half away from zero, halve, sign
  logic                    e2_vld_r;
  coord_t                  e2_off_r [NUM_OFFS];
  logic [2:0][COORD_W-1:0] e2_c_r;
  logic                    e2_deg_r;

  // e3: apex and base center
  logic   e3_vld_r;
  pt_t    e3_apex_r [3];
  pt_t    e3_base_r [3];
  coord_t e3_so_r   [3];
  coord_t e3_xo_r   [3];
  logic   e3_deg_r;

  // e4: all five points
  logic e4_vld_r;
  pt_t  e4_pt_r [NUM_PTS][3];
  logic e4_deg_r;

  // sequencer
  coord_t p_r [NUM_PTS][3];
  logic   deg_r;
  logic   act_r,  act_nxt;
  face_t  face_r, face_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_vld_r <= 1'b0;
      e2_vld_r <= 1'b0;
      e3_vld_r <= 1'b0;
      e4_vld_r <= 1'b0;
      act_r    <= 1'b0;
      face_r   <= FACE0;
    end else begin
      e1_vld_r <= in_vld;
      e2_vld_r <= e1_vld_r;
      e3_vld_r <= e2_vld_r;
      e4_vld_r <= e3_vld_r;
      act_r    <= act_nxt;
      face_r   <= face_nxt;
    end
  end

  always_ff @(posedge clk) begin : dp
    logic [UW-1:0] mag;
    logic [PW:0]   rsum;
    logic [COORD_W-1:0] rmag;
    for (int k = 0; k < NUM_OFFS; k++) begin
      mag = u_w[k][UW-1] ? (UW'(0) - u_w[k]) : u_w[k];
      e1_prod_r[k] <= mag[FRAC_BITS:0] * len_w[k];
      e1_neg_r[k]  <= u_w[k][UW-1];
    end
    e1_c_r   <= in_side.center;
    e1_deg_r <= in_deg;

    for (int k = 0; k < NUM_OFFS; k++) begin
      rsum = {1'b0, e1_prod_r[k]} + ((PW+1)'(1) << FRAC_BITS);
      rmag = COORD_W'(rsum >> (FRAC_BITS + 1));
      e2_off_r[k] <= e1_neg_r[k] ? (coord_t'(0) - coord_t'(rmag)) : coord_t'(rmag);
    end
    e2_c_r   <= e1_c_r;
    e2_deg_r <= e1_deg_r;

    for (int i = 0; i < 3; i++) begin
      e3_apex_r[i] <= pt_t'(coord_t'(e2_c_r[i])) + pt_t'(e2_off_r[i]);
      e3_base_r[i] <= pt_t'(coord_t'(e2_c_r[i])) - pt_t'(e2_off_r[i]);
      e3_so_r[i]   <= e2_off_r[3 + i];
      e3_xo_r[i]   <= e2_off_r[6 + i];
    end
    e3_deg_r <= e2_deg_r;

    for (int i = 0; i < 3; i++) begin
      e4_pt_r[PT_APEX][i] <= e3_apex_r[i];
      e4_pt_r[PT_MM][i] <= e3_base_r[i] - pt_t'(e3_so_r[i]) - pt_t'(e3_xo_r[i]);
      e4_pt_r[PT_MP][i] <= e3_base_r[i] - pt_t'(e3_so_r[i]) + pt_t'(e3_xo_r[i]);
      e4_pt_r[PT_PM][i] <= e3_base_r[i] + pt_t'(e3_so_r[i]) - pt_t'(e3_xo_r[i]);
      e4_pt_r[PT_PP][i] <= e3_base_r[i] + pt_t'(e3_so_r[i]) + pt_t'(e3_xo_r[i]);
    end
    e4_deg_r <= e3_deg_r;

    // hold the point bank for the six faces of one item
    if (e4_vld_r) begin
      for (int p = 0; p < NUM_PTS; p++) begin
        for (int i = 0; i < 3; i++) begin
          p_r[p][i] <= sat32(e4_pt_r[p][i]);
        end
      end
      deg_r <= e4_deg_r;
    end
  end

  always_comb begin
    act_nxt  = act_r;
    face_nxt = face_r;
    if (e4_vld_r) begin
      act_nxt  = 1'b1;
      face_nxt = FACE0;
    end else if (act_r) begin
      if (face_r == FACE_LAST) begin
        act_nxt = 1'b0;
      end else begin
        face_nxt = face_t'(face_r + 3'd1);
      end
    end
  end

  always_comb begin : sel
    logic [2:0] pa, pb, pc;
    case (face_r)
      FACE0:   begin pa = PT_APEX; pb = PT_MM; pc = PT_PM; end
      FACE1:   begin pa = PT_APEX; pb = PT_MP; pc = PT_MM; end
      FACE2:   begin pa = PT_APEX; pb = PT_MP; pc = PT_PP; end
      FACE3:   begin pa = PT_APEX; pb = PT_PP; pc = PT_PM; end
      FACE4:   begin pa = PT_PP;   pb = PT_MP; pc = PT_MM; end
      FACE5:   begin pa = PT_PP;   pb = PT_PM; pc = PT_MM; end
      default: begin pa = PT_APEX; pb = PT_MM; pc = PT_PM; end
    endcase
    out_vertex_a_x = p_r[pa][0];
    out_vertex_a_y = p_r[pa][1];
    out_vertex_a_z = p_r[pa][2];
    out_vertex_b_x = p_r[pb][0];
    out_vertex_b_y = p_r[pb][1];
    out_vertex_b_z = p_r[pb][2];
    out_vertex_c_x = p_r[pc][0];
    out_vertex_c_y = p_r[pc][1];
    out_vertex_c_z = p_r[pc][2];
  end

  assign out_valid       = act_r;
  assign out_face_number = face_r;
  assign out_final_face  = act_r && (face_r == FACE_LAST);
  assign out_degenerate  = deg_r;

endmodule

`default_nettype wire

// ----- design/square_pyramid_tessellator.sv -----
// Square pyramid tessellator top level: cross product front end, three
// vector normalizers and the face emitter. Depends on spt_pkg, spt_norm, spt_emit.
//
// Usage:
//   Input: drive the pyramid fields on in_* and raise start; the beat is
//   taken at a rising edge with start high and busy low.
//   Output: each pyramid yields six triangle beats on consecutive
//   cycles, each marked by out_valid for one cycle; out_face_number counts
//   0..5, out_final_face marks the sixth, out_degenerate repeats on all six.
//   Path: stages t1 and t2, the three normalizers and emitter stages e1 to e4
//   lead to the face register that puts the first triangle on the ports.
//   Pacing: busy stays high after each accepted beat, long enough for the
//   emitter to show six faces from one point bank. Behind the emitter the
//   pipeline takes a new beat any cycle.
//   Reset: synchronous, active low; clears all valid bits, the emitter and
//   busy, so nothing in flight survives it.
//   The receiver cannot stall: out_valid beats must be taken as they come.
`default_nettype none

module square_pyramid_tessellator import spt_pkg::*; #(
  parameter int COORD_FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  coord_t             in_center_x,
  input  coord_t             in_center_y,
  input  coord_t             in_center_z,
  input  coord_t             in_axis_x,
  input  coord_t             in_axis_y,
  input  coord_t             in_axis_z,
  input  coord_t             in_side_x,
  input  coord_t             in_side_y,
  input  coord_t             in_side_z,
  input  logic [DIM_W-1:0]   in_tip_height,
  input  logic [DIM_W-1:0]   in_base_size,
  output logic               out_valid,
  output coord_t             out_vertex_a_x,
  output coord_t             out_vertex_a_y,
  output coord_t             out_vertex_a_z,
  output coord_t             out_vertex_b_x,
  output coord_t             out_vertex_b_y,
  output coord_t             out_vertex_b_z,
  output coord_t             out_vertex_c_x,
  output coord_t             out_vertex_c_y,
  output coord_t             out_vertex_c_z,
  output logic [FACE_W-1:0]  out_face_number,
  output logic               out_final_face,
  output logic               out_degenerate
);

  localparam int UW       = COORD_FRAC_BITS + 2;
  localparam int NORM_LAT = 5 + ROOT_STAGES + 1 + (COORD_FRAC_BITS + 1) + 1;
  localparam int DLY      = 2 + NORM_LAT;

  logic             accept;
  logic [GAP_W-1:0] gap_r, gap_nxt;

  assign accept = start && !busy;
  assign busy   = (gap_r != '0);

  always_comb begin
    gap_nxt = gap_r;
    if (accept) begin
      gap_nxt = ITEM_GAP;
    end else if (gap_r != '0) begin
      gap_nxt = gap_r - GAP_W'(1);
    end
  end

  // t1: cross product partial products, raw axis and side
  logic                     t1_vld_r;
  logic signed [MAG_W-1:0]  t1_p_r [6];
  coord_t                   t1_a_r [3];
  coord_t                   t1_s_r [3];

  // t2: sign and magnitude for the three vectors
  logic                  t2_vld_r;
  logic [2:0][MAG_W-1:0] t2_am_r, t2_sm_r, t2_xm_r;
  logic [2:0]            t2_an_r, t2_sn_r, t2_xn_r;

  logic  v_r    [DLY];
  side_t side_r [DLY];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r    <= '0;
      t1_vld_r <= 1'b0;
      t2_vld_r <= 1'b0;
      for (int i = 0; i < DLY; i++) v_r[i] <= 1'b0;
    end else begin
      gap_r    <= gap_nxt;
      t1_vld_r <= accept;
      t2_vld_r <= t1_vld_r;
      v_r[0]   <= accept;
      for (int i = 1; i < DLY; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin : dp
    logic signed [MAG_W:0] df;
    logic [COORD_W-1:0]    am, sm;
    t1_p_r[0] <= in_side_y * in_axis_z;
    t1_p_r[1] <= in_side_z * in_axis_y;
    t1_p_r[2] <= in_side_z * in_axis_x;
    t1_p_r[3] <= in_side_x * in_axis_z;
    t1_p_r[4] <= in_side_x * in_axis_y;
    t1_p_r[5] <= in_side_y * in_axis_x;
    t1_a_r[0] <= in_axis_x;
    t1_a_r[1] <= in_axis_y;
    t1_a_r[2] <= in_axis_z;
    t1_s_r[0] <= in_side_x;
    t1_s_r[1] <= in_side_y;
    t1_s_r[2] <= in_side_z;

    for (int i = 0; i < 3; i++) begin
      df = t1_p_r[2*i] - t1_p_r[2*i+1];
      t2_xn_r[i] <= df[MAG_W];
      t2_xm_r[i] <= df[MAG_W] ? MAG_W'(-df) : MAG_W'(df);
      am = t1_a_r[i][COORD_W-1] ? (COORD_W'(0) - t1_a_r[i]) : t1_a_r[i];
      sm = t1_s_r[i][COORD_W-1] ? (COORD_W'(0) - t1_s_r[i]) : t1_s_r[i];
      t2_an_r[i] <= t1_a_r[i][COORD_W-1];
      t2_am_r[i] <= MAG_W'(am);
      t2_sn_r[i] <= t1_s_r[i][COORD_W-1];
      t2_sm_r[i] <= MAG_W'(sm);
    end

    side_r[0].center <= {in_center_z, in_center_y, in_center_x};
    side_r[0].height <= in_tip_height;
    side_r[0].size   <= in_base_size;
    for (int i = 1; i < DLY; i++) side_r[i] <= side_r[i-1];
  end

  logic [2:0]          nv;
  logic [2:0][UW-1:0]  ua, us, ux;
  logic                za, zs, zx;

  spt_norm #(.FRAC_BITS(COORD_FRAC_BITS)) u_norm_axis (
    .clk(clk), .rst_n(rst_n), .in_vld(t2_vld_r), .in_mag(t2_am_r), .in_neg(t2_an_r),
    .out_vld(nv[0]), .out_unit(ua), .out_zero(za)
  );

  spt_norm #(.FRAC_BITS(COORD_FRAC_BITS)) u_norm_side (
    .clk(clk), .rst_n(rst_n), .in_vld(t2_vld_r), .in_mag(t2_sm_r), .in_neg(t2_sn_r),
    .out_vld(nv[1]), .out_unit(us), .out_zero(zs)
  );

  spt_norm #(.FRAC_BITS(COORD_FRAC_BITS)) u_norm_cross (
    .clk(clk), .rst_n(rst_n), .in_vld(t2_vld_r), .in_mag(t2_xm_r), .in_neg(t2_xn_r),
    .out_vld(nv[2]), .out_unit(ux), .out_zero(zx)
  );

  spt_emit #(.FRAC_BITS(COORD_FRAC_BITS)) u_emit (
    .clk(clk), .rst_n(rst_n),
    .in_vld(&nv), .in_ua(ua), .in_us(us), .in_ux(ux),
    .in_side(side_r[DLY-1]), .in_deg(za | zs | zx),
    .out_valid(out_valid),
    .out_vertex_a_x(out_vertex_a_x), .out_vertex_a_y(out_vertex_a_y),
    .out_vertex_a_z(out_vertex_a_z),
    .out_vertex_b_x(out_vertex_b_x), .out_vertex_b_y(out_vertex_b_y),
    .out_vertex_b_z(out_vertex_b_z),
    .out_vertex_c_x(out_vertex_c_x), .out_vertex_c_y(out_vertex_c_y),
    .out_vertex_c_z(out_vertex_c_z),
    .out_face_number(out_face_number), .out_final_face(out_final_face),
    .out_degenerate(out_degenerate)
  );

  // normalizer timing must line up with the side delay line
  a_norm_align: assert property (@(posedge clk) disable iff (!rst_n)
    (nv[0] == v_r[DLY-1]) && (nv[1] == v_r[DLY-1]) && (nv[2] == v_r[DLY-1]))
    else $error("normalizer valid out of step with side data");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy low right after an accepted beat");

  a_face_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_final_face) |=>
      (out_valid && (out_face_number == $past(out_face_number) + 3'd1)))
    else $error("face sequence broken");

  a_final_face: assert property (@(posedge clk) disable iff (!rst_n)
    out_final_face |-> (out_valid && (out_face_number == FACE_LAST)))
    else $error("final face flag on the wrong beat");

endmodule

`default_nettype wire

// ----- tb/tb_square_pyramid_tessellator.sv -----
// Testbench for the square pyramid tessellator: drives pyramid beats and checks
// each of the six triangle beats against an in-bench fixed-point model.
// Depends on spt_pkg and square_pyramid_tessellator.
`timescale 1ns / 100ps

module tb_square_pyramid_tessellator import spt_pkg::*;;

  localparam int FB = FRAC_BITS_DEF;

  typedef struct {
    logic signed [31:0] c [3];
    logic signed [31:0] a [3];
    logic signed [31:0] s [3];
    logic [30:0] h;
    logic [30:0] d;
  } pyramid_t;

  typedef struct {
    logic signed [31:0] v [9];
    logic [2:0] face;
    logic last;
    logic deg;
  } tri_t;

  logic clk = 0, rst_n = 0, start = 0, busy;
  coord_t in_c [3] = '{default: 0};
  coord_t in_a [3] = '{default: 0};
  coord_t in_s [3] = '{default: 0};
  logic [30:0] in_h = 0, in_d = 0;
  logic out_valid;
  coord_t ov [9];
  logic [2:0] out_face;
  logic out_last, out_deg;

  pyramid_t pending_q [$];
  tri_t tri_q [$];
  int errors = 0;
  int send_idle = 0;
  int idle_pct [4] = '{0, 81, 0, 25};
  logic busy_at_edge = 1;
  string vname [9] = '{"vertex_a_x", "vertex_a_y", "vertex_a_z",
                       "vertex_b_x", "vertex_b_y", "vertex_b_z",
                       "vertex_c_x", "vertex_c_y", "vertex_c_z"};

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  square_pyramid_tessellator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_center_x(in_c[0]), .in_center_y(in_c[1]), .in_center_z(in_c[2]),
    .in_axis_x(in_a[0]), .in_axis_y(in_a[1]), .in_axis_z(in_a[2]),
    .in_side_x(in_s[0]), .in_side_y(in_s[1]), .in_side_z(in_s[2]),
    .in_tip_height(in_h), .in_base_size(in_d),
    .out_valid(out_valid),
    .out_vertex_a_x(ov[0]), .out_vertex_a_y(ov[1]), .out_vertex_a_z(ov[2]),
    .out_vertex_b_x(ov[3]), .out_vertex_b_y(ov[4]), .out_vertex_b_z(ov[5]),
    .out_vertex_c_x(ov[6]), .out_vertex_c_y(ov[7]), .out_vertex_c_z(ov[8]),
    .out_face_number(out_face), .out_final_face(out_last),
    .out_degenerate(out_deg)
  );

  function automatic logic [63:0] root64(input logic [63:0] x);
    logic [63:0] res, bits;
    res = 0;
    bits = 64'd1 << 62;
    while (bits > x) bits >>= 2;
    while (bits != 0) begin
      if (x >= res + bits) begin
        x -= res + bits;
        res = (res >> 1) + bits;
      end else begin
        res >>= 1;
      end
      bits >>= 2;
    end
    return res;
  endfunction

  // Unit vector from sign/magnitude; returns 0 when the vector is zero.
  function automatic bit unitize(input logic [63:0] m_in [3], input bit neg [3],
                                 output logic signed [63:0] u [3]);
    logic [63:0] m [3];
    logic [63:0] mx, len, q;
    m = m_in;
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return 0;
    end
    while (mx >= 64'h8000_0000) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < 64'h4000_0000) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    len = root64(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FB) + (len >> 1)) / len;
      u[i] = neg[i] ? -$signed(q) : $signed(q);
    end
    return 1;
  endfunction

  function automatic logic signed [63:0] half_offset(input logic signed [63:0] u,
                                                     input logic [30:0] len);
    logic [63:0] r, m;
    m = u < 0 ? -u : u;
    r = (m * {33'd0, len} + (64'd1 << FB)) >> (FB + 1);
    return u < 0 ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic void tessellate(input pyramid_t p);
    logic signed [63:0] a [3], s [3], ua [3], us [3], ux [3], pt [5][3];
    logic signed [63:0] pa, pb, ho, so, xo, b;
    logic [63:0] m [3];
    bit n [3];
    bit deg;
    int idx [3];
    int order [6][3] = '{'{0,1,3}, '{0,2,1}, '{0,2,4}, '{0,4,3}, '{4,2,1}, '{4,3,1}};
    tri_t t;
    deg = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = p.a[i];
      s[i] = p.s[i];
    end
    for (int i = 0; i < 3; i++) begin
      m[i] = a[i] < 0 ? -a[i] : a[i];
      n[i] = a[i] < 0;
    end
    if (!unitize(m, n, ua)) deg = 1;
    for (int i = 0; i < 3; i++) begin
      m[i] = s[i] < 0 ? -s[i] : s[i];
      n[i] = s[i] < 0;
    end
    if (!unitize(m, n, us)) deg = 1;
    // cross = side x axis, exact
    for (int i = 0; i < 3; i++) begin
      idx[0] = (i + 1) % 3;
      idx[1] = (i + 2) % 3;
      pa = s[idx[0]] * a[idx[1]];
      pb = s[idx[1]] * a[idx[0]];
      n[i] = pa < pb;
      m[i] = pa < pb ? pb - pa : pa - pb;
    end
    if (!unitize(m, n, ux)) deg = 1;
    for (int i = 0; i < 3; i++) begin
      ho = half_offset(ua[i], p.h);
      so = half_offset(us[i], p.d);
      xo = half_offset(ux[i], p.d);
      b = 64'(p.c[i]) - ho;
      pt[0][i] = 64'(p.c[i]) + ho;
      pt[1][i] = b - so - xo;
      pt[2][i] = b - so + xo;
      pt[3][i] = b + so - xo;
      pt[4][i] = b + so + xo;
    end
    for (int k = 0; k < 6; k++) begin
      for (int v = 0; v < 3; v++)
        for (int i = 0; i < 3; i++) t.v[v * 3 + i] = clamp32(pt[order[k][v]][i]);
      t.face = k[2:0];
      t.last = (k == int'(FACE_LAST));
      t.deg = deg;
      tri_q.push_back(t);
    end
  endfunction

  function automatic logic signed [31:0] rnd_coord(input int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 8'hff)) - 128;
      2: return $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000;
      default: return $urandom_range(0, 3) == 0 ? 32'sh7FFF_FFFF :
                      ($urandom_range(0, 1) ? 32'sh8000_0000 : 0);
    endcase
  endfunction

  function automatic pyramid_t rnd_pyramid();
    pyramid_t p;
    int mc, mv;
    mc = $urandom_range(0, 3);
    mv = $urandom_range(0, 3);
    for (int i = 0; i < 3; i++) begin
      p.c[i] = rnd_coord(mc);
      p.a[i] = rnd_coord(mv);
      p.s[i] = rnd_coord(mv == 3 ? 3 : $urandom_range(0, 2));
    end
    // drop some vectors to zero or parallel now and then
    if ($urandom_range(0, 15) == 0) p.a = '{0, 0, 0};
    if ($urandom_range(0, 15) == 0) p.s = '{0, 0, 0};
    if ($urandom_range(0, 15) == 0) p.s = p.a;
    p.h = $urandom_range(0, 1) ? 31'($urandom) : 31'($urandom_range(0, 32'h7ffff));
    p.d = $urandom_range(0, 1) ? 31'($urandom) : 31'($urandom_range(0, 32'h7ffff));
    return p;
  endfunction

  // Driver: present the head of the queue, advance on an accepted beat.
  always @(negedge clk) begin
    if (rst_n) begin
      if (start && !busy_at_edge) begin
        void'(pending_q.pop_front());
      end
      if (pending_q.size() != 0 && ($urandom_range(0, 99) >= send_idle)) begin
        start <= 1;
        in_c <= pending_q[0].c;
        in_a <= pending_q[0].a;
        in_s <= pending_q[0].s;
        in_h <= pending_q[0].h;
        in_d <= pending_q[0].d;
      end else begin
        start <= 0;
      end
    end
  end

  always @(posedge clk) begin
    busy_at_edge <= busy;
    if (rst_n && start && !busy) tessellate(pending_q[0]);
  end

  // Monitor: compare each triangle beat with the oldest expectation.
  always @(posedge clk) begin : mon
    tri_t e;
    if (rst_n && out_valid) begin
      if (tri_q.size() == 0) begin
        $error("unexpected triangle beat, face %0d", out_face);
        errors++;
      end else begin
        e = tri_q.pop_front();
        for (int i = 0; i < 9; i++)
          if (ov[i] !== e.v[i]) begin
            $error("%s: expected %0d, got %0d", vname[i], e.v[i], ov[i]);
            errors++;
          end
        if (out_face !== e.face) begin
          $error("face_number: expected %0d, got %0d", e.face, out_face);
          errors++;
        end
        if (out_last !== e.last) begin
          $error("final_face: expected %0d, got %0d", e.last, out_last);
          errors++;
        end
        if (out_deg !== e.deg) begin
          $error("degenerate: expected %0d, got %0d", e.deg, out_deg);
          errors++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("tb_square_pyramid_tessellator NOT OK");
    $finish;
  end

  initial begin
    pyramid_t p;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1;
    // directed: extremes, zero vectors, axis-aligned vectors, then random pyramids
    for (int k = 0; k < 20; k++) begin
      for (int i = 0; i < 3; i++) begin
        p.c[i] = (k % 3 == 0) ? 32'sh7FFF_FFFF : (k % 3 == 1) ? 32'sh8000_0000 : 0;
        p.a[i] = (i == 2) ? 32'sh0001_0000 : 0;
        p.s[i] = (i == 0) ? 32'sh0001_0000 : 0;
      end
      p.h = (k & 1) ? 31'h7FFF_FFFF : 31'h0002_0000;
      p.d = (k & 2) ? 31'h7FFF_FFFF : 31'h0001_0000;
      case (k)
        3: p.a = '{0, 0, 0};
        4: p.s = '{0, 0, 0};
        5: p.s = '{32'sh10000, 0, 32'sh10000};
        6: begin p.a = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
                  p.s = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0}; end
        7: begin p.a = '{1, 0, 0}; p.s = '{0, -1, 0}; end
        8: begin p.a = '{-32'sh3000, 32'sh7000, 5}; p.s = '{-1, -1, -1}; end
        9: begin p.h = 0; p.d = 0; end
        default: if (k > 9) p = rnd_pyramid();
      endcase
      pending_q.push_back(p);
    end
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = idle_pct[ph];
      for (int n = 0; n < 110; n++) pending_q.push_back(rnd_pyramid());
      wait (pending_q.size() == 0);
    end
    wait (tri_q.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0)
      $display("tb_square_pyramid_tessellator OK");
    else
      $display("tb_square_pyramid_tessellator NOT OK");
    $finish;
  end

endmodule

// ----- sim.f -----
design/spt_pkg.sv
design/spt_norm.sv
design/spt_emit.sv
design/square_pyramid_tessellator.sv
tb/tb_square_pyramid_tessellator.sv
